@@ hw/rtl/udp_status_message_parser_core_assert.svh @@
// assertion helpers; every macro samples on clk and is disabled while arst_n is low
`ifndef UDP_STATUS_MESSAGE_PARSER_CORE_ASSERT_SVH
`define UDP_STATUS_MESSAGE_PARSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define USMP_ASSERT_HOLDS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`define USMP_ASSERT_IMPL(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) else $error(msg);

`define USMP_ASSERT_NEXT(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) else $error(msg);

`else

`define USMP_ASSERT_HOLDS(lbl, cond, msg)

`define USMP_ASSERT_IMPL(lbl, ant, con, msg)

`define USMP_ASSERT_NEXT(lbl, ant, con, msg)

`endif

`endif

@@ hw/rtl/usmp_pkg.sv @@
package usmp_pkg;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_MAGIC  = 3'd1,
		ST_OTHER_TYPE = 3'd2,
		ST_EARLY      = 3'd3,
		ST_ZERO_FREQ  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		K_W32  = 2'd0,
		K_TEXT = 2'd1,
		K_W64  = 2'd2,
		K_BOOL = 2'd3
	} kind_t;

	localparam logic [4:0] FLD_MAGIC = 5'd0;
	localparam logic [4:0] FLD_TYPE  = 5'd2;
	localparam logic [4:0] FLD_FREQ  = 5'd4;
	localparam logic [4:0] FLD_CALL  = 5'd6;
	localparam logic [4:0] FLD_GRID  = 5'd16;
	localparam logic [4:0] FLD_DONE  = 5'd17;
	localparam logic [4:0] FLD_DROP  = 5'd18;

	localparam logic [31:0] MAGIC_WORD = 32'hADBCCBDA;
	localparam logic [31:0] NULL_LEN   = 32'hFFFFFFFF;
	localparam logic [31:0] MSG_STATUS = 32'd1;

	typedef struct packed {
		status_t     status;
		logic [63:0] freq;
		logic [63:0] call_text;
		logic [3:0]  call_len;
		logic        call_cut;
		logic [63:0] grid_text;
		logic [3:0]  grid_len;
		logic        grid_cut;
	} usmp_result_t;

	// layout of the status message fields, from the header words on
	function automatic kind_t field_kind(input logic [4:0] fld);
		kind_t k;
		unique case (fld)
			5'd0, 5'd1, 5'd2, 5'd12, 5'd13:       k = K_W32;
			5'd3, 5'd5, 5'd6, 5'd7, 5'd8,
			5'd14, 5'd15, 5'd16:                  k = K_TEXT;
			5'd4:                                 k = K_W64;
			5'd9, 5'd10, 5'd11:                   k = K_BOOL;
			default:                              k = K_W32;
		endcase
		return k;
	endfunction

endpackage

@@ hw/rtl/usmp_parser.sv @@
`include "udp_status_message_parser_core_assert.svh"

module usmp_parser
	import usmp_pkg::*;
#(
	parameter int CALL_CHARS = 8,
	parameter int GRID_CHARS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   data_byte,
	input  logic         last_byte,
	output usmp_result_t res
);

	localparam int CW = 8 * CALL_CHARS;
	localparam int GW = 8 * GRID_CHARS;
	localparam int CPAD = 64 - CW;
	localparam int GPAD = 64 - GW;

	logic [4:0]    fld_q, fld_nxt;
	logic [31:0]   bc_q, bc_nxt;
	logic [31:0]   len_q, len_nxt;
	logic [63:0]   ws_q, ws_nxt;
	logic [63:0]   freq_q, freq_nxt;
	logic [CW-1:0] call_q, call_nxt;
	logic [GW-1:0] grid_q, grid_nxt;
	status_t       err_q, err_nxt;
	logic          body_q, body_nxt;
	logic [3:0]    ccnt_q, ccnt_nxt;
	logic [3:0]    gcnt_q, gcnt_nxt;
	logic          ccut_q, ccut_nxt;
	logic          gcut_q, gcut_nxt;

	kind_t       kind;
	logic        adv;
	logic [31:0] bc_inc;
	logic [63:0] ws_shift;
	logic [31:0] ws_len;

	assign kind     = field_kind(fld_q);
	assign bc_inc   = bc_q + 32'd1;
	assign ws_shift = {ws_q[55:0], data_byte};
	assign ws_len   = ws_shift[31:0];

	always_comb begin
		fld_nxt  = fld_q;
		bc_nxt   = bc_q;
		len_nxt  = len_q;
		ws_nxt   = ws_q;
		freq_nxt = freq_q;
		call_nxt = call_q;
		grid_nxt = grid_q;
		err_nxt  = err_q;
		body_nxt = body_q;
		ccnt_nxt = ccnt_q;
		gcnt_nxt = gcnt_q;
		ccut_nxt = ccut_q;
		gcut_nxt = gcut_q;
		adv      = 1'b0;
		if (step && fld_q < FLD_DONE) begin
			if (kind == K_TEXT && body_q) begin
				if (fld_q == FLD_CALL) begin
					if (bc_q < 32'(CALL_CHARS)) begin
						for (int j = 0; j < CALL_CHARS; j++) begin
							if (bc_q[2:0] == 3'(j))
								call_nxt[CW-8-8*j +: 8] = data_byte;
						end
						ccnt_nxt = bc_inc[3:0];
					end else begin
						ccut_nxt = 1'b1;
					end
				end else if (fld_q == FLD_GRID) begin
					if (bc_q < 32'(GRID_CHARS)) begin
						for (int j = 0; j < GRID_CHARS; j++) begin
							if (bc_q[2:0] == 3'(j))
								grid_nxt[GW-8-8*j +: 8] = data_byte;
						end
						gcnt_nxt = bc_inc[3:0];
					end else begin
						gcut_nxt = 1'b1;
					end
				end
				bc_nxt = bc_inc;
				if (bc_inc >= len_q)
					adv = 1'b1;
			end else if (kind == K_BOOL) begin
				adv = 1'b1;
			end else begin
				ws_nxt = ws_shift;
				bc_nxt = bc_inc;
				if (bc_inc >= ((kind == K_W64) ? 32'd8 : 32'd4)) begin
					priority if (kind == K_TEXT) begin
						// all-ones length is the empty-text marker
						if (ws_len == NULL_LEN || ws_len == 32'd0) begin
							adv = 1'b1;
						end else begin
							len_nxt  = ws_len;
							body_nxt = 1'b1;
							bc_nxt   = 32'd0;
							ws_nxt   = 64'd0;
						end
					end else if (fld_q == FLD_MAGIC && ws_len != MAGIC_WORD) begin
						err_nxt = ST_BAD_MAGIC;
						fld_nxt = FLD_DROP;
					end else if (fld_q == FLD_TYPE && ws_len != MSG_STATUS) begin
						err_nxt = ST_OTHER_TYPE;
						fld_nxt = FLD_DROP;
					end else begin
						if (fld_q == FLD_FREQ)
							freq_nxt = ws_shift;
						adv = 1'b1;
					end
				end
			end
			if (adv) begin
				fld_nxt  = fld_q + 5'd1;
				bc_nxt   = 32'd0;
				ws_nxt   = 64'd0;
				len_nxt  = 32'd0;
				body_nxt = 1'b0;
			end
		end
	end

	always_comb begin
		priority if (err_nxt != ST_OK)
			res.status = err_nxt;
		else if (fld_nxt != FLD_DONE)
			res.status = ST_EARLY;
		else if (freq_nxt == 64'd0)
			res.status = ST_ZERO_FREQ;
		else
			res.status = ST_OK;
		res.freq      = freq_nxt;
		res.call_text = 64'(call_nxt) << CPAD;
		res.call_len  = ccnt_nxt;
		res.call_cut  = ccut_nxt;
		res.grid_text = 64'(grid_nxt) << GPAD;
		res.grid_len  = gcnt_nxt;
		res.grid_cut  = gcut_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fld_q  <= FLD_MAGIC;
			bc_q   <= '0;
			len_q  <= '0;
			ws_q   <= '0;
			freq_q <= '0;
			call_q <= '0;
			grid_q <= '0;
			err_q  <= ST_OK;
			body_q <= 1'b0;
			ccnt_q <= '0;
			gcnt_q <= '0;
			ccut_q <= 1'b0;
			gcut_q <= 1'b0;
		end else if (step && last_byte) begin
			// datagram done, start clean for the next one
			fld_q  <= FLD_MAGIC;
			bc_q   <= '0;
			len_q  <= '0;
			ws_q   <= '0;
			freq_q <= '0;
			call_q <= '0;
			grid_q <= '0;
			err_q  <= ST_OK;
			body_q <= 1'b0;
			ccnt_q <= '0;
			gcnt_q <= '0;
			ccut_q <= 1'b0;
			gcut_q <= 1'b0;
		end else if (step) begin
			fld_q  <= fld_nxt;
			bc_q   <= bc_nxt;
			len_q  <= len_nxt;
			ws_q   <= ws_nxt;
			freq_q <= freq_nxt;
			call_q <= call_nxt;
			grid_q <= grid_nxt;
			err_q  <= err_nxt;
			body_q <= body_nxt;
			ccnt_q <= ccnt_nxt;
			gcnt_q <= gcnt_nxt;
			ccut_q <= ccut_nxt;
			gcut_q <= gcut_nxt;
		end
	end

	`USMP_ASSERT_HOLDS(a_fld_range, fld_q <= FLD_DROP, "field index out of range")
	`USMP_ASSERT_IMPL(a_err_drop, err_q != ST_OK, fld_q == FLD_DROP, "error without drop")
	`USMP_ASSERT_IMPL(a_body_len, body_q, len_q != 32'd0 && field_kind(fld_q) == K_TEXT, "bad text body")
	`USMP_ASSERT_IMPL(a_call_cut, ccut_q, ccnt_q == 4'(CALL_CHARS), "call cut before full")
	`USMP_ASSERT_NEXT(a_restart, step && last_byte, fld_q == FLD_MAGIC && !body_q, "no restart after last")

endmodule

@@ hw/rtl/udp_status_message_parser_core.sv @@
// Status datagram parser: takes one datagram byte per clock on the input channel, with
// packet_last on the final byte, and gives one status word per datagram on the output
// channel. A byte is registered on entry and then parsed by the field walker; the status
// word for a datagram is registered in the result register when its last byte leaves the
// input register, and is held there while the output is stalled.
// Throughput is one byte per clock with no gaps between datagrams; the input only stalls
// when a last byte is waiting while the previous status word is still held by a stalled
// output.
module udp_status_message_parser_core
	import usmp_pkg::*;
#(
	parameter int CALL_CHARS = 8,
	parameter int GRID_CHARS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  packet_byte,
	input  logic        packet_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  parse_status,
	output logic [63:0] dial_freq_hz,
	output logic [63:0] call_text,
	output logic [3:0]  call_len,
	output logic        call_cut,
	output logic [63:0] grid_text,
	output logic [3:0]  grid_len,
	output logic        grid_cut
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         retire;
	logic         accept;
	logic         out_valid_q;
	usmp_result_t res;
	usmp_result_t res_q;

	// a last byte may only leave stage 1 once the result register can take it
	assign retire   = valid_s1 && !(last_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !retire;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (retire)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= packet_byte;
			last_s1 <= packet_last;
		end
	end

	usmp_parser #(
		.CALL_CHARS(CALL_CHARS),
		.GRID_CHARS(GRID_CHARS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (retire),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (retire && last_s1)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (retire && last_s1)
			res_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign parse_status = res_q.status;
	assign dial_freq_hz = res_q.freq;
	assign call_text    = res_q.call_text;
	assign call_len     = res_q.call_len;
	assign call_cut     = res_q.call_cut;
	assign grid_text    = res_q.grid_text;
	assign grid_len     = res_q.grid_len;
	assign grid_cut     = res_q.grid_cut;

endmodule
